// File: src/pet_pkg.sv
package pet_pkg;

	// Command codes carried on s_tuser
	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SET  = 2'd1,
		CMD_KILL = 2'd2
	} cmd_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_WRITE,
		ST_KILL,
		ST_FLUSH
	} state_t;

	// One timer slot as it travels around the ring
	typedef struct packed {
		logic [7:0]  event_id;
		logic [7:0]  param;
		logic [15:0] remaining;
		logic [15:0] period;
	} slot_t;

	// Controls from the sequencer to the head unit
	typedef struct packed {
		logic clr;    // new command accepted: clear scan bookkeeping
		logic adv;    // ring rotates by one slot this cycle
		logic tick;   // tick pass
		logic scan;   // set, search pass
		logic write;  // set, write pass
		logic kill;   // kill pass
	} walk_ctrl_t;

endpackage

// File: src/pet_cell.sv
module pet_cell import pet_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  slot_t d,
	output slot_t q
);

	logic [7:0]  event_id_q;
	logic [7:0]  param_q;
	logic [15:0] remaining_q;
	logic [15:0] period_q;

	// Event id resets to zero so every slot starts free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_id_q <= '0;
		end else if (shift) begin
			event_id_q <= d.event_id;
		end
	end

	// Payload fields
	always_ff @(posedge clk) begin
		if (shift) begin
			param_q     <= d.param;
			remaining_q <= d.remaining;
			period_q    <= d.period;
		end
	end

	assign q = '{event_id: event_id_q, param: param_q, remaining: remaining_q,
		period: period_q};

endmodule

// File: src/pet_head.sv
module pet_head import pet_pkg::*; #(
	parameter int MAX_TIMERS = 16,
	localparam int IW = $clog2(MAX_TIMERS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  walk_ctrl_t    ctrl,
	input  logic [IW-1:0] idx,
	input  logic [IW-1:0] hw,
	input  logic [7:0]    event_id,
	input  logic [7:0]    event_param,
	input  logic [15:0]   delay_ticks,
	input  slot_t         head,
	output slot_t         nxt,
	output logic          fire,
	output logic          wr_ok,
	output logic [IW-1:0] wr_tgt,
	output logic [IW-1:0] kill_hw
);

	logic          match_q, free_q;
	logic [IW-1:0] tgt_q, lastu_q;
	logic          match_d, free_d;
	logic [IW-1:0] tgt_d, lastu_d;
	logic [IW:0]   hw_next;
	logic          above_ok;

	// Slot just above the mark, if the bank has room
	assign hw_next  = {1'b0, hw} + (IW+1)'(1);
	assign above_ok = hw_next < (IW+1)'(MAX_TIMERS);
	assign wr_ok    = match_q || free_q || above_ok;
	assign wr_tgt   = (match_q || free_q) ? tgt_q : hw_next[IW-1:0];

	// Work on the slot now at the head of the ring
	always_comb begin
		nxt     = head;
		fire    = 1'b0;
		match_d = match_q;
		free_d  = free_q;
		tgt_d   = tgt_q;
		lastu_d = lastu_q;

		if (ctrl.tick && head.event_id != '0) begin
			if (head.remaining != '0) begin
				nxt.remaining = head.remaining - 16'd1;
			end else begin
				fire          = 1'b1;
				nxt.remaining = head.period - 16'd1;
			end
		end

		// First match wins; otherwise remember the highest free slot
		if (ctrl.scan && idx <= hw && !match_q) begin
			if (head.event_id == '0) begin
				free_d = 1'b1;
				tgt_d  = idx;
			end else if (head.event_id == event_id) begin
				match_d = 1'b1;
				tgt_d   = idx;
			end
		end

		if (ctrl.write && wr_ok && idx == wr_tgt) begin
			nxt.event_id  = event_id;
			nxt.param     = event_param;
			nxt.remaining = delay_ticks;
			nxt.period    = delay_ticks;
		end

		// Free matching slots and track the highest slot still in use
		if (ctrl.kill) begin
			if (head.event_id == event_id) begin
				nxt.event_id = '0;
			end
			if (nxt.event_id != '0) begin
				lastu_d = idx;
			end
		end

		kill_hw = lastu_d;
	end

	// Pass bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			tgt_q   <= '0;
			lastu_q <= '0;
		end else if (ctrl.clr) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			tgt_q   <= '0;
			lastu_q <= '0;
		end else if (ctrl.adv) begin
			match_q <= match_d;
			free_q  <= free_d;
			tgt_q   <= tgt_d;
			lastu_q <= lastu_d;
		end
	end

endmodule

// File: src/periodic_event_timer_bank.sv
// Bank of MAX_TIMERS periodic timers kept in a ring of slot cells that rotates one slot per
// cycle past a single head unit while a pass runs and the output does not hold it. A command
// is taken only when the previous one is finished (s_tready high only in idle). A tick takes
// one rotation and then a flush step, and its fired events leave in slot order with tlast on
// the final one; a set with nonzero delay takes two rotations (search, then write); a kill
// takes one rotation; a set with zero delay goes straight to the flush step. A busy output
// holds the rotation whenever a second fired event needs room. A tick that fires nothing, a
// kill, a stored set and a set with zero delay and id zero give no transfer.
module periodic_event_timer_bank import pet_pkg::*; #(
	parameter int MAX_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // event_id[7:0], event_param[15:8], delay_ticks[31:16]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // fired_id[7:0], fired_param[15:8]
	output logic        m_tlast    // last_of_run
);

	localparam int IW = $clog2(MAX_TIMERS);

	state_t        state_q, state_d;
	logic [IW-1:0] idx_q, hw_q;
	logic [7:0]    id_q, par_q;
	logic [15:0]   delay_q;
	logic          pv_q;
	logic [7:0]    pend_id_q, pend_par_q;
	logic          out_v_q, out_last_q;
	logic [7:0]    out_id_q, out_par_q;

	walk_ctrl_t    ctrl;
	slot_t         cq [MAX_TIMERS];
	slot_t         head_nxt;
	logic          fire, wr_ok;
	logic [IW-1:0] wr_tgt, kill_hw;
	logic          accept, out_free, walking, last_step, push_pend, flush_pend;
	cmd_t          cmd;

	assign cmd       = cmd_t'(s_tuser);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_v_q || m_tready;
	assign last_step = idx_q == IW'(MAX_TIMERS - 1);

	// Ring of slot cells, head at index 0, head unit feeds the tail
	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_ring
		slot_t d;
		if (i == MAX_TIMERS - 1) begin : g_tail
			assign d = head_nxt;
		end else begin : g_mid
			assign d = cq[i+1];
		end
		pet_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (ctrl.adv),
			.d     (d),
			.q     (cq[i])
		);
	end

	pet_head #(.MAX_TIMERS(MAX_TIMERS)) u_head (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.idx        (idx_q),
		.hw         (hw_q),
		.event_id   (id_q),
		.event_param(par_q),
		.delay_ticks(delay_q),
		.head       (cq[0]),
		.nxt        (head_nxt),
		.fire       (fire),
		.wr_ok      (wr_ok),
		.wr_tgt     (wr_tgt),
		.kill_hw    (kill_hw)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and pass controls
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		walking    = 1'b0;
		ctrl       = '0;
		flush_pend = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (cmd)
						CMD_TICK: state_d = ST_TICK;
						CMD_SET:  state_d = (s_tdata[31:16] == '0) ? ST_FLUSH : ST_SCAN;
						CMD_KILL: state_d = ST_KILL;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK, ST_SCAN, ST_WRITE, ST_KILL: begin
				walking    = 1'b1;
				ctrl.tick  = state_q == ST_TICK;
				ctrl.scan  = state_q == ST_SCAN;
				ctrl.write = state_q == ST_WRITE;
				ctrl.kill  = state_q == ST_KILL;
			end
			ST_FLUSH: begin
				if (!pv_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush_pend = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		ctrl.clr = accept;
		// A second fired event needs the output stage free before the ring moves on
		ctrl.adv = walking && !(fire && pv_q && !out_free);
		if (ctrl.adv && last_step) begin
			unique case (state_q)
				ST_TICK:  state_d = ST_FLUSH;
				ST_SCAN:  state_d = ST_WRITE;
				default:  state_d = ST_IDLE;
			endcase
		end
	end

	assign push_pend = ctrl.adv && fire;

	// Slot counter and high-water mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hw_q  <= '0;
		end else if (ctrl.adv) begin
			idx_q <= last_step ? '0 : idx_q + IW'(1);
			if (last_step && state_q == ST_WRITE && wr_ok && wr_tgt > hw_q) begin
				hw_q <= wr_tgt;
			end else if (last_step && state_q == ST_KILL) begin
				hw_q <= kill_hw;
			end
		end
	end

	// Command fields held for the passes
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= s_tdata[7:0];
			par_q   <= s_tdata[15:8];
			delay_q <= s_tdata[31:16];
		end
	end

	// Pending event and output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept && cmd == CMD_SET && s_tdata[31:16] == '0 && s_tdata[7:0] != '0) begin
				pv_q <= 1'b1;
			end else if (push_pend) begin
				pv_q <= 1'b1;
			end else if (flush_pend) begin
				pv_q <= 1'b0;
			end
			if ((push_pend && pv_q) || flush_pend) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Pending event and output stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_id_q  <= s_tdata[7:0];
			pend_par_q <= s_tdata[15:8];
		end else if (push_pend) begin
			pend_id_q  <= cq[0].event_id;
			pend_par_q <= cq[0].param;
		end
		if ((push_pend && pv_q) || flush_pend) begin
			out_id_q   <= pend_id_q;
			out_par_q  <= pend_par_q;
			out_last_q <= flush_pend;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_par_q, out_id_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pv_q)
		else $error("pending event left over in idle");

	a_idle_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> idx_q == '0)
		else $error("ring not back in slot order at idle");

	a_hw_only_on_pass_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_WRITE || state_q == ST_KILL) |=> $stable(hw_q))
		else $error("high-water mark moved outside a write or kill pass");

	a_push_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		push_pend |=> pv_q && out_v_q == $past(out_v_q && !m_tready || pv_q))
		else $error("fired event lost between pending and output stages");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb import pet_pkg::*; ();

	localparam int NSLOT = 16;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 3 * NSLOT + 8;

	// One fired event as it should leave the block
	typedef struct packed {
		bit [7:0] id;
		bit [7:0] param;
		bit       last;
	} fired_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // event_id[7:0], event_param[15:8], delay_ticks[31:16]
	logic [1:0]  s_tuser;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // fired_id[7:0], fired_param[15:8]
	logic        m_tlast;

	// Timer bank mirror
	bit [7:0]  tmr_id [NSLOT];
	bit [7:0]  tmr_param [NSLOT];
	bit [15:0] tmr_left [NSLOT];
	bit [15:0] tmr_period [NSLOT];
	int        tmr_top;

	fired_t      fired_q[$];
	fired_t      fired_want;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	bit          src_idle_en;
	bit          sink_idle_en;
	bit          sink_hold_req;

	periodic_event_timer_bank #(
		.MAX_TIMERS(NSLOT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	// Update the timer mirror for one command and queue the events it fires
	function automatic void fire_and_update(cmd_t cmd, bit [7:0] id, bit [7:0] par,
			bit [15:0] dly);
		int base;
		int tgt;
		bit got_free;
		base = fired_q.size();
		case (cmd)
			CMD_TICK: begin
				for (int i = 0; i <= tmr_top; i++) begin
					if (tmr_id[i] != 8'd0) begin
						if (tmr_left[i] != 16'd0) begin
							tmr_left[i] = tmr_left[i] - 16'd1;
						end else begin
							fired_q.push_back('{tmr_id[i], tmr_param[i], 1'b0});
							tmr_left[i] = tmr_period[i] - 16'd1;
						end
					end
				end
			end
			CMD_SET: begin
				if (dly == 16'd0) begin
					if (id != 8'd0)
						fired_q.push_back('{id, par, 1'b0});
				end else begin
					tgt = NSLOT;
					got_free = 1'b0;
					for (int i = 0; i <= tmr_top; i++) begin
						if (tmr_id[i] == 8'd0) begin
							tgt = i;
							got_free = 1'b1;
						end else if (tmr_id[i] == id) begin
							// refresh the first running timer with this id
							tmr_param[i] = par;
							tmr_left[i] = dly;
							tmr_period[i] = dly;
							return;
						end
					end
					if (!got_free)
						tgt = tmr_top + 1;
					// bank full: the request is dropped
					if (tgt < NSLOT) begin
						tmr_id[tgt] = id;
						tmr_param[tgt] = par;
						tmr_left[tgt] = dly;
						tmr_period[tgt] = dly;
						if (tgt > tmr_top)
							tmr_top = tgt;
					end
				end
			end
			CMD_KILL: begin
				for (int i = 0; i < NSLOT; i++)
					if (tmr_id[i] == id)
						tmr_id[i] = 8'd0;
				while (tmr_top > 0 && tmr_id[tmr_top] == 8'd0)
					tmr_top--;
			end
			default: ;
		endcase
		if (fired_q.size() > base)
			fired_q[fired_q.size() - 1].last = 1'b1;
	endfunction

	// Offer one command; returns at a falling edge after the transfer
	task automatic send_item(cmd_t cmd, bit [7:0] id, bit [7:0] par, bit [15:0] dly);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dly, par, id};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		fire_and_update(cmd, id, par, dly);
		@(negedge clk);
	endtask

	// Mostly small ids and short periods so timers collide, refresh and fire
	task automatic send_random_item();
		int roll;
		bit [7:0] id;
		bit [15:0] dly;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			id = 8'($urandom_range(0, 255));
		else
			id = 8'($urandom_range(1, 12));
		case ($urandom_range(0, 7))
			0: dly = 16'd0;
			1: dly = 16'($urandom);
			2: dly = 16'hFFFF;
			default: dly = 16'($urandom_range(1, 4));
		endcase
		if (roll < 45)
			send_item(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
		else if (roll < 82)
			send_item(CMD_SET, id, 8'($urandom), dly);
		else
			send_item(CMD_KILL, id, 8'($urandom), 16'($urandom));
	endtask

	// Stop offering and wait for every queued event to come out
	task automatic wait_all_fired();
		s_tvalid <= 1'b0;
		while (fired_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_immediate();
		send_item(CMD_SET, 8'd255, 8'd255, 16'd0);
		send_item(CMD_SET, 8'd1, 8'd0, 16'd0);
		// id zero with no delay fires nothing
		send_item(CMD_SET, 8'd0, 8'h5A, 16'd0);
	endtask

	task automatic test_bank_full();
		for (int k = 0; k < NSLOT; k++)
			send_item(CMD_SET, 8'(k + 1), 8'(8'hA5 ^ k), 16'd1);
		// no free slot left: dropped
		send_item(CMD_SET, 8'd200, 8'h11, 16'd1);
		send_item(CMD_SET, 8'd7, 8'hFF, 16'd1);
		send_item(CMD_TICK, 8'd0, 8'd0, 16'd0);
		// every slot fires on this tick
		send_item(CMD_TICK, 8'hFF, 8'hFF, 16'hFFFF);
	endtask

	task automatic test_kill_and_reuse();
		send_item(CMD_KILL, 8'd16, 8'd0, 16'd0);
		send_item(CMD_KILL, 8'd0, 8'd0, 16'd0);
		send_item(CMD_KILL, 8'd9, 8'd0, 16'd0);
		// id zero lands in a free slot and leaves it free
		send_item(CMD_SET, 8'd0, 8'd0, 16'hFFFF);
		send_item(CMD_SET, 8'd255, 8'd0, 16'hFFFF);
		send_item(CMD_TICK, 8'd0, 8'd0, 16'd0);
	endtask

	task automatic test_random_mix(int count);
		repeat (count)
			send_random_item();
	endtask

	// Sink holds off while ticks keep coming, so the block stalls its input
	task automatic test_output_stall();
		for (int k = 0; k < 6; k++)
			send_item(CMD_SET, 8'(30 + k), 8'($urandom), 16'($urandom_range(1, 2)));
		sink_hold_req = 1'b1;
		repeat (24)
			send_item(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	task automatic test_drain_pause();
		test_random_mix(15);
		wait_all_fired();
		test_random_mix(15);
	endtask

	task automatic test_no_idle(int count);
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		test_random_mix(count);
	endtask

	// Ready for the result side: random bursts, one long hold on request
	initial begin : sink_ready
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
			end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each fired event with the oldest one queued
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (fired_q.size() == 0) begin
				$error("unexpected fired event id=%0d param=%0d", m_tdata[7:0], m_tdata[15:8]);
				fail_count++;
			end else begin
				fired_want = fired_q.pop_front();
				if (m_tdata[7:0] !== fired_want.id) begin
					$error("fired_id: expected %0d, got %0d", fired_want.id, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[15:8] !== fired_want.param) begin
					$error("fired_param: expected %0d, got %0d", fired_want.param,
						m_tdata[15:8]);
					fail_count++;
				end
				if (m_tlast !== fired_want.last) begin
					$error("last_of_run: expected %0d, got %0d", fired_want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[periodic_event_timer_bank] ERROR");
				$finish;
			end
		end
	end

	initial begin : main
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_TICK;
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		sink_hold_req = 1'b0;
		tmr_top = 0;
		for (int i = 0; i < NSLOT; i++)
			tmr_id[i] = 8'd0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;

		test_immediate();
		test_bank_full();
		test_kill_and_reuse();
		test_random_mix(200);
		test_output_stall();
		test_drain_pause();
		test_no_idle(50);

		wait_all_fired();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fired_q.size() != 0) begin
			$error("%0d fired events never arrived", fired_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("[periodic_event_timer_bank] OK");
		else
			$display("[periodic_event_timer_bank] ERROR");
		$finish;
	end

endmodule
